### sv/mf_pkg.sv
// ----------------------------------------------------------------------------
// mf_pkg: shared types and constants of the 3x3 median filter
// Frame geometry limits, queue entry layout and small compare helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package mf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIX_W      = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int WCFG_W     = 11;
  localparam int HCFG_W     = 13;
  localparam int CFG_W      = 13;
  localparam int IDX_W      = 2;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = IDX_W'(1);

  typedef logic [PIX_W-1:0] pix_t;

  // one full 3x3 window, unsorted, plus what the emitter needs
  typedef struct packed {
    pix_t [8:0]       win;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [3:0]       mask;
    logic             use_med;
  } q_entry_t;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

endpackage

`default_nettype wire

### sv/mf_if.sv
// ----------------------------------------------------------------------------
// mf_if: channel interfaces of the 3x3 median filter
// Pixel input, result output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface mf_pix_if;
  import mf_pkg::*;
  logic valid;
  logic ready;
  pix_t pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface mf_res_if;
  import mf_pkg::*;
  logic             valid;
  logic             ready;
  pix_t             value;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic             last;
  modport source (output valid, output value, output out_row, output out_col,
                  output last, input ready);
  modport sink   (input valid, input value, input out_row, input out_col,
                  input last, output ready);
endinterface

interface mf_cfg_if;
  import mf_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] idx;
  logic [CFG_W-1:0] data;
  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

### sv/mf_front.sv
// ----------------------------------------------------------------------------
// mf_front: pixel intake, line stores and window
// Tracks row and column, reads the two line stores, shifts the 3x3 window
// and pushes one entry per pixel into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mf_front
  import mf_pkg::*;
(
  input  wire      clk,
  input  wire      rst,
  mf_pix_if.sink   pix,
  mf_cfg_if.sink   cfg,
  output q_entry_t q_data,
  output logic     q_push,
  input  wire      q_full
);

  logic [COL_W-1:0] wm1;
  logic [ROW_W-1:0] hm1;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;

  logic             s1_valid;
  pix_t             s1_pix;
  logic [ROW_W-1:0] s1_row;
  logic [COL_W-1:0] s1_col;
  logic [3:0]       s1_mask;
  logic             s1_use_med;

  pix_t rd_above;
  pix_t rd_two;
  pix_t [8:0] window;
  pix_t [8:0] window_next;

  pix_t mem_above [MAX_WIDTH];
  pix_t mem_two   [MAX_WIDTH];

  logic accept;
  logic leave;
  logic r_ge1, c_ge1, c_eq, r_eq;
  logic [WCFG_W-1:0] wcfg;
  logic [HCFG_W-1:0] hcfg;

  assign leave     = s1_valid && !q_full;
  assign pix.ready = !s1_valid || leave;
  assign accept    = pix.valid && pix.ready;
  assign cfg.ready = 1'b1;

  assign wcfg = cfg.data[WCFG_W-1:0];
  assign hcfg = cfg.data[HCFG_W-1:0];

  // register writes, stored as last index with clamping applied
  always_ff @(posedge clk) begin
    if (rst) begin
      wm1 <= COL_W'(MAX_WIDTH - 1);
      hm1 <= ROW_W'(1023);
    end else if (cfg.valid) begin
      if (cfg.idx == REG_IMAGE_WIDTH) begin
        if (wcfg == '0)
          wm1 <= '0;
        else if (wcfg > WCFG_W'(MAX_WIDTH))
          wm1 <= COL_W'(MAX_WIDTH - 1);
        else
          wm1 <= COL_W'(wcfg - WCFG_W'(1));
      end else if (cfg.idx == REG_IMAGE_HEIGHT) begin
        if (hcfg == '0)
          hm1 <= '0;
        else if (hcfg > HCFG_W'(MAX_HEIGHT))
          hm1 <= ROW_W'(MAX_HEIGHT - 1);
        else
          hm1 <= ROW_W'(hcfg - HCFG_W'(1));
      end
    end
  end

  assign r_ge1 = (row != '0);
  assign c_ge1 = (col != '0);
  assign c_eq  = (col == wm1);
  assign r_eq  = (row == hm1);

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      if (col >= wm1) begin
        col <= '0;
        row <= (row >= hm1) ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix.ready) begin
      s1_valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix     <= pix.pixel;
      s1_row     <= row;
      s1_col     <= col;
      s1_mask    <= {r_eq & c_eq, r_eq & c_ge1, r_ge1 & c_eq, r_ge1 & c_ge1};
      s1_use_med <= (row >= ROW_W'(2)) && (col >= COL_W'(2));
    end
  end

  // line stores: write when the entry leaves, forward on same-column hit
  always_ff @(posedge clk) begin
    if (leave) begin
      mem_above[s1_col[ADDR_W-1:0]] <= s1_pix;
      mem_two[s1_col[ADDR_W-1:0]]   <= rd_above;
    end
    if (accept) begin
      if (leave && (s1_col == col)) begin
        rd_above <= s1_pix;
        rd_two   <= rd_above;
      end else begin
        rd_above <= mem_above[col[ADDR_W-1:0]];
        rd_two   <= mem_two[col[ADDR_W-1:0]];
      end
    end
  end

  always_comb begin
    window_next    = window;
    window_next[0] = window[1];
    window_next[1] = window[2];
    window_next[2] = rd_two;
    window_next[3] = window[4];
    window_next[4] = window[5];
    window_next[5] = rd_above;
    window_next[6] = window[7];
    window_next[7] = window[8];
    window_next[8] = s1_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (leave) begin
      window <= window_next;
    end
  end

  assign q_push          = leave;
  assign q_data.win      = window_next;
  assign q_data.row      = s1_row;
  assign q_data.col      = s1_col;
  assign q_data.mask     = s1_mask;
  assign q_data.use_med  = s1_use_med;

endmodule

`default_nettype wire

### sv/mf_queue.sv
// ----------------------------------------------------------------------------
// mf_queue: small queue between intake and median/emit side
// Holds window entries so either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module mf_queue
  import mf_pkg::*;
(
  input  wire      clk,
  input  wire      rst,
  input  wire      push,
  input  q_entry_t wr_data,
  output logic     full,
  input  wire      pop,
  output q_entry_t rd_data,
  output logic     empty
);

  q_entry_t slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop)
        count <= count + (QPTR_W+1)'(1);
      else if (pop && !push)
        count <= count - (QPTR_W+1)'(1);
    end
  end

endmodule

`default_nettype wire

### sv/mf_back.sv
// ----------------------------------------------------------------------------
// mf_back: median network and result emitter
// Sorts window columns in one stage, finishes the median on load into the
// emitter, then sends up to four results per entry.
// ----------------------------------------------------------------------------
`default_nettype none

module mf_back
  import mf_pkg::*;
(
  input  wire      clk,
  input  wire      rst,
  input  q_entry_t q_data,
  input  wire      q_empty,
  output logic     q_pop,
  mf_res_if.source res
);

  // column sort stage
  logic             a_valid;
  pix_t [2:0]       a_lo, a_mid, a_hi;
  pix_t             a_w4, a_w5, a_w7, a_w8;
  logic [ROW_W-1:0] a_row;
  logic [COL_W-1:0] a_col;
  logic [3:0]       a_mask;
  logic             a_use_med;
  logic             a_ready;

  // emitter
  logic [3:0]       b_mask;
  pix_t [3:0]       b_val;
  logic [ROW_W-1:0] b_row;
  logic [COL_W-1:0] b_col;
  logic             b_load;
  logic [3:0]       sel;
  logic             res_beat;
  pix_t             median;

  assign res_beat = res.valid && res.ready;
  assign sel      = b_mask & (~b_mask + 4'd1);
  assign b_load   = (b_mask == '0) || (res_beat && ((b_mask & ~sel) == '0));
  assign a_ready  = !a_valid || b_load;
  assign q_pop    = !q_empty && a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int k = 0; k < 3; k++) begin
        a_lo[k]  <= min3(q_data.win[k], q_data.win[k+3], q_data.win[k+6]);
        a_mid[k] <= med3(q_data.win[k], q_data.win[k+3], q_data.win[k+6]);
        a_hi[k]  <= max3(q_data.win[k], q_data.win[k+3], q_data.win[k+6]);
      end
      a_w4      <= q_data.win[4];
      a_w5      <= q_data.win[5];
      a_w7      <= q_data.win[7];
      a_w8      <= q_data.win[8];
      a_row     <= q_data.row;
      a_col     <= q_data.col;
      a_mask    <= q_data.mask;
      a_use_med <= q_data.use_med;
    end
  end

  assign median = med3(max3(a_lo[0], a_lo[1], a_lo[2]),
                       med3(a_mid[0], a_mid[1], a_mid[2]),
                       min3(a_hi[0], a_hi[1], a_hi[2]));

  always_ff @(posedge clk) begin
    if (rst) begin
      b_mask <= '0;
    end else if (b_load) begin
      b_mask <= a_valid ? a_mask : 4'b0000;
    end else if (res_beat) begin
      b_mask <= b_mask & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load && a_valid) begin
      b_val[0] <= a_use_med ? median : a_w4;
      b_val[1] <= a_w5;
      b_val[2] <= a_w7;
      b_val[3] <= a_w8;
      b_row    <= a_row;
      b_col    <= a_col;
    end
  end

  // results in order: upper-left, upper right column, own row, own corner
  always_comb begin
    res.value   = b_val[3];
    res.out_row = b_row;
    res.out_col = b_col;
    priority if (b_mask[0]) begin
      res.value   = b_val[0];
      res.out_row = b_row - ROW_W'(1);
      res.out_col = b_col - COL_W'(1);
    end else if (b_mask[1]) begin
      res.value   = b_val[1];
      res.out_row = b_row - ROW_W'(1);
    end else if (b_mask[2]) begin
      res.value   = b_val[2];
      res.out_col = b_col - COL_W'(1);
    end
  end

  assign res.valid = (b_mask != '0);
  assign res.last  = ((b_mask & ~sel) == '0);

endmodule

`default_nettype wire

### sv/median_filter_3x3.sv
// ----------------------------------------------------------------------------
// median_filter_3x3: 3x3 median filter over a raster pixel stream
// Interior pixels get the median of their neighborhood, border pixels pass.
// ----------------------------------------------------------------------------
//  channel | dir | fields                          | beat
//  pix     | in  | pixel                           | valid & ready
//  res     | out | value, out_row, out_col, last   | valid & ready
//  cfg     | in  | idx (0 width, 1 height), data   | valid & ready (always)
//
//  one pixel per cycle sustained unless res stalls or the emitter is busy with a
//  pixel that yields several results, up to four at row and frame ends.
//  a pixel passes the s1 register, the queue, the column sort stage and the emitter.
//  a four-entry queue parts intake from the median/emit side; stalls on res
//  back up through the queue to pix.ready.
//  synchronous reset; no clearing pass, line stores are written before use.
// ----------------------------------------------------------------------------
`default_nettype none

module median_filter_3x3
  import mf_pkg::*;
(
  input  wire      clk,
  input  wire      rst,
  mf_pix_if.sink   pix,
  mf_res_if.source res,
  mf_cfg_if.sink   cfg
);

  q_entry_t q_wr;
  q_entry_t q_rd;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  mf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .pix    (pix),
    .cfg    (cfg),
    .q_data (q_wr),
    .q_push (q_push),
    .q_full (q_full)
  );

  mf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  mf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_rd),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

`default_nettype wire
